@@ rtl/huffman_code_bit_packer_top_macros.svh @@
// Assertion macros used by the checker file of the bit packer.
`ifndef HUFFMAN_CODE_BIT_PACKER_TOP_MACROS_SVH
`define HUFFMAN_CODE_BIT_PACKER_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define HCBP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hcbp assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define HCBP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hcbp assertion failed");

`endif

@@ rtl/hcbp_pkg.sv @@
// Package: mode codes and controller/datapath interface types for the bit packer.
package hcbp_pkg;

   localparam int MODE_W = 2;
   localparam int BYTE_W = 8;

   localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ENCODE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FINISH = 2'd2;

   typedef struct packed {
      logic tbl_write;   // store the incoming table entry
      logic tbl_read;    // fetch the entry for the incoming symbol
      logic acc_load;    // capture merged accumulator and bit total
      logic pend_read;   // fold a short code straight into the pending bits
      logic byte_emit;   // send the next complete code word
      logic pad_emit;    // send the zero-padded partial word
      logic hdr_emit;    // send the padding-count header word
   } hcbp_cmd_type;

   typedef struct packed {
      logic sym_ok;      // symbol lies inside the table
      logic read_ge8;    // merged total holds at least one full word
      logic emit_last;   // word being sent is the last of this symbol
      logic cnt_nz;      // pending bits exist
      logic slot_free;   // output register can take a word
   } hcbp_sts_type;

endpackage

@@ rtl/hcbp_ctrl.sv @@
// Controller state machine of the bit packer.
module hcbp_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [hcbp_pkg::MODE_W-1:0] req_mode,
   input  hcbp_pkg::hcbp_sts_type    sts,
   output hcbp_pkg::hcbp_cmd_type    cmd
);
   import hcbp_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_EMIT = 3'd2;
   localparam logic [2:0] S_PAD  = 3'd3;
   localparam logic [2:0] S_HDR  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid & req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_mode)
                  MODE_LOAD: begin
                     cmd.tbl_write = sts.sym_ok;
                  end
                  MODE_ENCODE: begin
                     if (sts.sym_ok) begin
                        cmd.tbl_read = 1'b1;
                        state_in     = S_READ;
                     end
                  end
                  MODE_FINISH: begin
                     state_in = S_PAD;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_READ: begin
            if (sts.read_ge8) begin
               cmd.acc_load = 1'b1;
               state_in     = S_EMIT;
            end else begin
               cmd.pend_read = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_EMIT: begin
            if (sts.slot_free) begin
               cmd.byte_emit = 1'b1;
               if (sts.emit_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_PAD: begin
            if (sts.slot_free) begin
               if (sts.cnt_nz) begin
                  cmd.pad_emit = 1'b1;
                  state_in     = S_HDR;
               end else begin
                  cmd.hdr_emit = 1'b1;
                  state_in     = S_IDLE;
               end
            end
         end
         S_HDR: begin
            if (sts.slot_free) begin
               cmd.hdr_emit = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/hcbp_dp.sv @@
// Datapath of the bit packer: code table, bit accumulator, pending bits, output register.
module hcbp_dp #(
   parameter int MAX_CODE_LEN = 32,
   parameter int SYMBOL_COUNT = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [7:0]               req_symbol,
   input  logic [31:0]              req_code_bits,
   input  logic [5:0]               req_code_length,
   input  hcbp_pkg::hcbp_cmd_type   cmd,
   output hcbp_pkg::hcbp_sts_type   sts,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_is_header,
   output logic                     rsp_last
);
   import hcbp_pkg::*;

   localparam int LEN_LIM = (MAX_CODE_LEN > 32) ? 32 : MAX_CODE_LEN;
   localparam int IDX_W   = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
   localparam int ENT_W   = LEN_LIM + 6;
   localparam int ACC_W   = LEN_LIM + 7;

   // code table
   logic [ENT_W-1:0]        tbl_mem [SYMBOL_COUNT];
   logic [SYMBOL_COUNT-1:0] tbl_vld_ff;
   logic [ENT_W-1:0]        rd_data_ff;
   logic                    rd_vld_ff;
   logic [IDX_W-1:0]        idx;
   logic [5:0]              len_sat;
   logic [31:0]             code_mask;
   logic [ENT_W-1:0]        entry;

   // accumulator and pending bits
   logic [ACC_W-1:0]        acc_ff;
   logic [5:0]              total_ff;
   logic [6:0]              pend_ff;
   logic [2:0]              cnt_ff;
   logic [LEN_LIM-1:0]      rd_code;
   logic [5:0]              rd_len;
   logic [ACC_W-1:0]        acc_read;
   logic [5:0]              total_read;
   logic [5:0]              total_rem;
   logic [ACC_W-1:0]        acc_shift;
   logic [14:0]             pad_shift;
   logic [7:0]              pad_byte;
   logic [7:0]              hdr_byte;

   // output register
   logic                    out_vld_ff;
   logic [7:0]              out_byte_ff;
   logic                    out_hdr_ff;
   logic                    out_last_ff;

   assign idx        = req_symbol[IDX_W-1:0];
   assign sts.sym_ok = ({1'b0, req_symbol} < 9'(SYMBOL_COUNT));

   // saturate the length, drop code bits above it
   assign len_sat   = (req_code_length > 6'(LEN_LIM)) ? 6'(LEN_LIM) : req_code_length;
   assign code_mask = ~(32'hffff_ffff << len_sat);
   assign entry     = {len_sat, LEN_LIM'(req_code_bits & code_mask)};

   always_ff @(posedge clock) begin
      if (cmd.tbl_write) begin
         tbl_mem[idx] <= entry;
      end
      if (cmd.tbl_read) begin
         rd_data_ff <= tbl_mem[idx];
         rd_vld_ff  <= tbl_vld_ff[idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tbl_vld_ff <= '0;
      end else if (cmd.tbl_write) begin
         tbl_vld_ff[idx] <= 1'b1;
      end
   end

   // an entry never written reads as length zero
   assign rd_code    = rd_vld_ff ? rd_data_ff[LEN_LIM-1:0] : '0;
   assign rd_len     = rd_vld_ff ? rd_data_ff[ENT_W-1:LEN_LIM] : '0;
   assign acc_read   = (ACC_W'(pend_ff) << rd_len) | ACC_W'(rd_code);
   assign total_read = 6'(cnt_ff) + rd_len;
   assign sts.read_ge8 = (total_read >= 6'd8);

   assign total_rem     = total_ff - 6'd8;
   assign acc_shift     = acc_ff >> total_rem;
   assign sts.emit_last = (total_ff < 6'd16);
   assign sts.cnt_nz    = (cnt_ff != 3'd0);

   assign pad_shift = 15'(pend_ff) << (4'd8 - {1'b0, cnt_ff});
   assign pad_byte  = pad_shift[7:0];
   assign hdr_byte  = (cnt_ff == 3'd0) ? 8'd0 : 8'(4'd8 - {1'b0, cnt_ff});

   always_ff @(posedge clock) begin
      if (cmd.acc_load) begin
         acc_ff   <= acc_read;
         total_ff <= total_read;
      end else if (cmd.byte_emit) begin
         total_ff <= total_rem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         cnt_ff  <= '0;
      end else if (cmd.pend_read) begin
         cnt_ff  <= total_read[2:0];
         pend_ff <= acc_read[6:0] & ~(7'h7f << total_read[2:0]);
      end else if (cmd.byte_emit && sts.emit_last) begin
         cnt_ff  <= total_rem[2:0];
         pend_ff <= acc_ff[6:0] & ~(7'h7f << total_rem[2:0]);
      end else if (cmd.hdr_emit) begin
         pend_ff <= '0;
         cnt_ff  <= '0;
      end
   end

   assign sts.slot_free = ~out_vld_ff | rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (cmd.byte_emit || cmd.pad_emit || cmd.hdr_emit) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.byte_emit) begin
         out_byte_ff <= acc_shift[7:0];
         out_hdr_ff  <= 1'b0;
         out_last_ff <= sts.emit_last;
      end else if (cmd.pad_emit) begin
         out_byte_ff <= pad_byte;
         out_hdr_ff  <= 1'b0;
         out_last_ff <= 1'b0;
      end else if (cmd.hdr_emit) begin
         out_byte_ff <= hdr_byte;
         out_hdr_ff  <= 1'b1;
         out_last_ff <= 1'b1;
      end
   end

   assign rsp_valid     = out_vld_ff;
   assign rsp_out_byte  = out_byte_ff;
   assign rsp_is_header = out_hdr_ff;
   assign rsp_last      = out_last_ff;

endmodule

@@ rtl/huffman_code_bit_packer_top.sv @@
// Top level of the table-driven Huffman code bit packer.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/ready    | mode, symbol, code_bits, code_length
//   rsp     | out       | rsp_valid/ready    | out_byte, is_header, last
//
// Load is taken in the idle state. Encode reads the code table into a register, then
// sends each complete word (0 to 4) through the one-word output register. Finish
// sends the zero-padded partial word when bits are pending, then the header. A stalled
// rsp side holds the sequencer; a finished word may wait while the next req is taken.
// Reset clears the table valid bits at once: every symbol reads as length zero.
module huffman_code_bit_packer_top #(
   parameter int MAX_CODE_LEN = 32,
   parameter int SYMBOL_COUNT = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [hcbp_pkg::MODE_W-1:0]   req_mode,
   input  logic [7:0]                    req_symbol,
   input  logic [31:0]                   req_code_bits,
   input  logic [5:0]                    req_code_length,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [hcbp_pkg::BYTE_W-1:0]   rsp_out_byte,
   output logic                          rsp_is_header,
   output logic                          rsp_last
);
   import hcbp_pkg::*;

   hcbp_cmd_type cmd;
   hcbp_sts_type sts;

   hcbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_mode),
      .sts       (sts),
      .cmd       (cmd)
   );

   hcbp_dp #(
      .MAX_CODE_LEN (MAX_CODE_LEN),
      .SYMBOL_COUNT (SYMBOL_COUNT)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_symbol      (req_symbol),
      .req_code_bits   (req_code_bits),
      .req_code_length (req_code_length),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_is_header   (rsp_is_header),
      .rsp_last        (rsp_last)
   );

endmodule

@@ rtl/hcbp_checker.sv @@
// Port-level checker of the bit packer and its bind to the top level.
`include "huffman_code_bit_packer_top_macros.svh"

module hcbp_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [hcbp_pkg::MODE_W-1:0]   req_mode,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [hcbp_pkg::BYTE_W-1:0]   rsp_out_byte,
   input logic                          rsp_is_header,
   input logic                          rsp_last
);
   import hcbp_pkg::*;

   logic [BYTE_W+1:0] rsp_word;

   assign rsp_word = {rsp_out_byte, rsp_is_header, rsp_last};

   // a stalled word holds
   `HCBP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word))
   // the header word closes the finish
   `HCBP_ASSERT_NOW(a_hdr_last, rsp_valid && rsp_is_header, rsp_last)
   // the padding count never reaches a full word
   `HCBP_ASSERT_NOW(a_hdr_range, rsp_valid && rsp_is_header, rsp_out_byte < 8'd8)
   // a finish blocks the next request while it flushes
   `HCBP_ASSERT_NEXT(a_fin_busy, req_valid && req_ready && req_mode == MODE_FINISH, !req_ready)

endmodule

bind huffman_code_bit_packer_top hcbp_checker u_hcbp_checker (.*);

@@ sim/huffman_code_bit_packer_top_tb.sv @@
// Self-checking testbench for the table-driven Huffman code bit packer.
`timescale 1ns / 1ps

module huffman_code_bit_packer_top_tb;
   import hcbp_pkg::*;

   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 335;
   localparam int CYCLE_LIMIT = 300000;
   localparam int HOLD_CYCLES = 400;
   localparam int HOLD_AT_ITEM = 120;
   localparam int PAUSE_AT_ITEM = 250;
   localparam int TAIL_CYCLES = 20;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_header;
      logic       last;
   } word_type;

   // typed_n of zero means the row is checked against the packer model
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [7:0]        symbol;
      logic [31:0]       code_bits;
      logic [5:0]        code_length;
      logic [1:0]        typed_n;
      word_type          first;
      word_type          second;
   } row_type;

   localparam word_type HDR_EMPTY = '{8'h00, 1'b1, 1'b1};

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [MODE_W-1:0] req_mode = MODE_LOAD;
   logic [7:0]        req_symbol = '0;
   logic [31:0]       req_code_bits = '0;
   logic [5:0]        req_code_length = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [BYTE_W-1:0] rsp_out_byte;
   logic              rsp_is_header;
   logic              rsp_last;

   // packer model state
   logic [31:0] code_mem [256] = '{default: '0};
   logic [5:0]  len_mem [256] = '{default: '0};
   logic [6:0]  pend_bits = '0;
   logic [2:0]  pend_count = '0;

   word_type packed_words[$];
   word_type expected_words[$];
   int    mismatch_count = 0;
   int    accepted_items = 0;
   int    cycle_count = 0;

   huffman_code_bit_packer_top DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_symbol     (req_symbol),
      .req_code_bits  (req_code_bits),
      .req_code_length(req_code_length),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_is_header  (rsp_is_header),
      .rsp_last       (rsp_last)
   );

   always #10 clock = ~clock;

   // Advance the packer model by one request and leave its output bytes in packed_words.
   function automatic void pack_item(input logic [MODE_W-1:0] mode, input logic [7:0] sym,
                                     input logic [31:0] bits, input logic [5:0] len);
      logic [5:0]  l;
      logic [38:0] acc;
      int          total;
      word_type    w;
      packed_words.delete();
      case (mode)
         MODE_LOAD: begin
            l = (len > 6'd32) ? 6'd32 : len;
            code_mem[sym] = 32'(64'(bits) & ((64'd1 << l) - 64'd1));
            len_mem[sym] = l;
         end
         MODE_ENCODE: begin
            l = len_mem[sym];
            acc = (39'(pend_bits) << l) | 39'(code_mem[sym]);
            total = int'(pend_count) + int'(l);
            while (total >= 8) begin
               total -= 8;
               w.out_byte = 8'(acc >> total);
               w.is_header = 1'b0;
               w.last = (total < 8);
               packed_words.push_back(w);
            end
            pend_count = 3'(total);
            pend_bits = 7'(acc & ((39'd1 << total) - 39'd1));
         end
         MODE_FINISH: begin
            if (pend_count != 0) begin
               w.out_byte = 8'(16'(pend_bits) << (8 - pend_count));
               w.is_header = 1'b0;
               w.last = 1'b0;
               packed_words.push_back(w);
               w.out_byte = 8'(8 - pend_count);
            end else begin
               w.out_byte = 8'h00;
            end
            w.is_header = 1'b1;
            w.last = 1'b1;
            packed_words.push_back(w);
            pend_bits = '0;
            pend_count = '0;
         end
         default: ;
      endcase
   endfunction

   function automatic row_type mk(input logic [MODE_W-1:0] mode, input logic [7:0] sym,
                                  input logic [31:0] bits, input logic [5:0] len);
      row_type r;
      r = '0;
      r.mode = mode;
      r.symbol = sym;
      r.code_bits = bits;
      r.code_length = len;
      return r;
   endfunction

   function automatic row_type mk_typed(input logic [MODE_W-1:0] mode, input logic [7:0] sym,
                                        input logic [31:0] bits, input logic [5:0] len,
                                        input logic [1:0] n, input word_type first,
                                        input word_type second);
      row_type r;
      r = mk(mode, sym, bits, len);
      r.typed_n = n;
      r.first = first;
      r.second = second;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("MISMATCH at %0t: %s want %0h got %0h", $time, what, want, got);
      mismatch_count++;
   endtask

   // Call at a falling edge; returns at the falling edge after the request is taken.
   task automatic offer(input row_type r);
      req_valid <= 1'b1;
      req_mode <= r.mode;
      req_symbol <= r.symbol;
      req_code_bits <= r.code_bits;
      req_code_length <= r.code_length;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pack_item(r.mode, r.symbol, r.code_bits, r.code_length);
      if (r.typed_n == 0) begin
         foreach (packed_words[i]) expected_words.push_back(packed_words[i]);
      end else begin
         expected_words.push_back(r.first);
         if (r.typed_n == 2) expected_words.push_back(r.second);
      end
      accepted_items++;
      @(negedge clock);
   endtask

   task automatic idle(input int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   task automatic wait_drained;
      req_valid <= 1'b0;
      @(negedge clock);
      while (expected_words.size() != 0) @(negedge clock);
   endtask

   always @(posedge clock) begin
      word_type got;
      word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_out_byte, rsp_is_header, rsp_last};
         if (expected_words.size() == 0) begin
            report_mismatch("word with none expected", '0, 32'(got));
         end else begin
            want = expected_words.pop_front();
            if (got.out_byte !== want.out_byte)
               report_mismatch("out_byte", 32'(want.out_byte), 32'(got.out_byte));
            if (got.is_header !== want.is_header)
               report_mismatch("is_header", 32'(want.is_header), 32'(got.is_header));
            if (got.last !== want.last)
               report_mismatch("last", 32'(want.last), 32'(got.last));
         end
      end
   end

   // Receiver: stall patterns that change after each random span, plus one long hold.
   initial begin
      int  pattern;
      int  span;
      bit  hold_done;
      hold_done = 1'b0;
      forever begin
         if (!hold_done && accepted_items >= HOLD_AT_ITEM) begin
            hold_done = 1'b1;
            repeat (HOLD_CYCLES) begin
               @(negedge clock);
               rsp_ready <= 1'b0;
            end
         end
         pattern = $urandom_range(0, 3);
         span = $urandom_range(8, 64);
         repeat (span) begin
            @(negedge clock);
            case (pattern)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      row_type    directed[$];
      row_type    r;
      logic [7:0] loaded_syms[$];
      int         random_done;
      int         burst;
      int         pick;
      bit         pause_done;

      // finish on an empty stream, zero-length codes, unused mode
      directed.push_back(mk_typed(MODE_FINISH, 8'h00, '0, '0, 2'd1, HDR_EMPTY, '0));
      directed.push_back(mk(MODE_ENCODE, 8'h00, '0, '0));
      directed.push_back(mk(MODE_UNUSED, 8'hA5, 32'hDEAD_BEEF, 6'd17));
      // table loads: full length, one bit, overlong, zero length, junk above length
      directed.push_back(mk(MODE_LOAD, 8'h41, 32'hFFFF_FFFF, 6'd32));
      directed.push_back(mk(MODE_LOAD, 8'hFF, 32'h0000_0001, 6'd1));
      directed.push_back(mk(MODE_LOAD, 8'h00, 32'h8000_0001, 6'd63));
      directed.push_back(mk(MODE_LOAD, 8'h20, 32'hFFFF_FFFF, 6'd0));
      directed.push_back(mk(MODE_LOAD, 8'h7E, 32'hFFFF_FFFD, 6'd3));
      directed.push_back(mk(MODE_LOAD, 8'h01, 32'h0000_0000, 6'd32));
      directed.push_back(mk(MODE_ENCODE, 8'h41, '0, '0));
      directed.push_back(mk(MODE_ENCODE, 8'hFF, '0, '0));
      directed.push_back(mk(MODE_ENCODE, 8'h00, '0, '0));
      directed.push_back(mk(MODE_ENCODE, 8'h7E, '0, '0));
      directed.push_back(mk(MODE_ENCODE, 8'h20, '0, '0));
      directed.push_back(mk(MODE_FINISH, 8'h00, '0, '0));
      directed.push_back(mk_typed(MODE_FINISH, 8'h00, '0, '0, 2'd1, HDR_EMPTY, '0));
      directed.push_back(mk(MODE_ENCODE, 8'h01, '0, '0));
      // seven pending bits, then finish with one padding bit
      directed.push_back(mk(MODE_ENCODE, 8'h7E, '0, '0));
      directed.push_back(mk(MODE_ENCODE, 8'h7E, '0, '0));
      directed.push_back(mk(MODE_ENCODE, 8'hFF, '0, '0));
      directed.push_back(mk(MODE_FINISH, 8'h00, '0, '0));
      directed.push_back(mk(MODE_LOAD, 8'h41, 32'h0000_00A5, 6'd8));
      directed.push_back(mk_typed(MODE_ENCODE, 8'h41, '0, '0, 2'd1,
                                  '{8'hA5, 1'b0, 1'b1}, '0));
      directed.push_back(mk(MODE_LOAD, 8'hFF, 32'h1234_5678, 6'd33));
      directed.push_back(mk(MODE_ENCODE, 8'hFF, '0, '0));
      directed.push_back(mk_typed(MODE_FINISH, 8'h00, '0, '0, 2'd1, HDR_EMPTY, '0));

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         offer(directed[i]);
         if ($urandom_range(0, 3) == 0) idle($urandom_range(1, 5));
      end
      loaded_syms = '{8'h41, 8'hFF, 8'h00, 8'h7E, 8'h01, 8'h20};

      random_done = 0;
      pause_done = 1'b0;
      while (random_done < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 24);
         repeat (burst) begin
            r = '0;
            r.code_bits = $urandom();
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
               r.mode = MODE_LOAD;
               r.symbol = 8'($urandom_range(0, 255));
               pick = $urandom_range(0, 99);
               if (pick < 5) r.code_length = 6'd0;
               else if (pick < 60) r.code_length = 6'($urandom_range(1, 10));
               else if (pick < 88) r.code_length = 6'($urandom_range(11, 32));
               else r.code_length = 6'($urandom_range(33, 63));
               loaded_syms.push_back(r.symbol);
            end else if (pick < 89) begin
               r.mode = MODE_ENCODE;
               r.code_length = 6'($urandom_range(0, 63));
               if ($urandom_range(0, 3) != 0)
                  r.symbol = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
               else
                  r.symbol = 8'($urandom_range(0, 255));
            end else if (pick < 97) begin
               r.mode = MODE_FINISH;
               r.symbol = 8'($urandom_range(0, 255));
               r.code_length = 6'($urandom_range(0, 63));
            end else begin
               r.mode = MODE_UNUSED;
               r.symbol = 8'($urandom_range(0, 255));
               r.code_length = 6'($urandom_range(0, 63));
            end
            offer(r);
            if (r.mode != MODE_UNUSED) random_done++;
         end
         if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 8));
         // hold the sender until every queued byte has come out
         if (!pause_done && random_done >= PAUSE_AT_ITEM) begin
            pause_done = 1'b1;
            wait_drained();
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
